// File: rtl/foah_pkg.sv
// foah_pkg: shared types, constants and arithmetic helpers for the fft overlap-add
// hilbert block. No dependencies; used by foah_ctrl, foah_dp and the top level.
`default_nettype none

package foah_pkg;

  typedef enum logic [3:0] {
    ST_IDLE, ST_LOAD_RD, ST_LOAD_WR, ST_BF_RD, ST_BF_MUL, ST_BF_ADD, ST_BF_WA,
    ST_BF_WB, ST_WT_RD, ST_WT_WR, ST_OUT_RD, ST_OUT_WR
  } foah_state_t;

  typedef enum logic [3:0] {
    OP_NONE, OP_LOAD_RD, OP_LOAD_WR, OP_BF_RD, OP_BF_MUL, OP_BF_ADD, OP_BF_WA,
    OP_BF_WB, OP_WT_RD, OP_WT_WR, OP_OUT_RD, OP_OUT_WR
  } foah_op_t;

  typedef struct packed {
    foah_op_t op;
    logic     inv;    // inverse transform on the upper work bank
    logic     idle;
  } foah_cmd_t;

  typedef struct packed {
    logic start;      // a full block of samples is waiting
  } foah_sts_t;

  localparam longint unsigned PI_Q30 = 64'd3373259426;

  function automatic logic signed [23:0] sat24(input logic signed [29:0] v);
    if (v > 30'sd8388607) return 24'sh7fffff;
    else if (v < -30'sd8388608) return 24'sh800000;
    else return v[23:0];
  endfunction

  function automatic logic signed [17:0] sat18(input logic signed [21:0] v);
    if (v > 22'sd131071) return 18'sh1ffff;
    else if (v < -22'sd131072) return 18'sh20000;
    else return v[17:0];
  endfunction

  // q4.20 to q5.15 with rounding
  function automatic logic signed [19:0] q15(input logic signed [23:0] v);
    logic signed [24:0] t;
    t = 25'(v) + 25'sd16;
    return t[24:5];
  endfunction

  // shift-subtract quotient, used only while building the twiddle table
  function automatic longint unsigned udiv64(input longint unsigned num,
                                             input longint unsigned den);
    longint unsigned q, r;
    q = '0;
    r = '0;
    for (int b = 63; b >= 0; b--) begin
      r = {r[62:0], num[b]};
      if (r >= den) begin
        r    = r - den;
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  // twiddle entry k of a 2^log2n point transform: {cos, sin} in q2.22,
  // evaluated at elaboration only
  function automatic logic [47:0] tw_entry(input int k, input int log2n);
    longint unsigned kk, x, x2, tc, ts;
    longint sc, ss, c, s;
    logic flip;
    flip = (4 * k) > (1 << log2n);
    kk = flip ? longint'((1 << (log2n - 1)) - k) : longint'(k);
    x = (PI_Q30 * 64'd2 * kk) >> log2n;
    x2 = (x * x) >> 30;
    tc = 64'd1 << 30;
    ts = x;
    sc = longint'(tc);
    ss = longint'(ts);
    for (int n = 1; n <= 12; n++) begin
      tc = udiv64((tc * x2) >> 30, 64'((2 * n - 1) * (2 * n)));
      ts = udiv64((ts * x2) >> 30, 64'((2 * n) * (2 * n + 1)));
      if ((n & 1) != 0) begin
        sc = sc - longint'(tc);
        ss = ss - longint'(ts);
      end else begin
        sc = sc + longint'(tc);
        ss = ss + longint'(ts);
      end
    end
    c = (sc + 64'sd128) >>> 8;
    s = (ss + 64'sd128) >>> 8;
    if (flip) c = -c;
    return {c[23:0], s[23:0]};
  endfunction

endpackage

`default_nettype wire

// File: rtl/fft_overlap_add_hilbert.sv
// fft_overlap_add_hilbert: streaming analytic-signal generator, fft overlap-add.
// Instantiates foah_ctrl and foah_dp; depends on foah_pkg.
//
// Usage: in_* carries one real q1.15 sample per request, out_* one complex q3.15
// sample per accepted input (re in the low 18 bits of out_tdata, im above).
// Each output comes from the previous block's buffer and is registered in the
// cycle after the input request; outputs are zero until the first block is done.
// Between block boundaries a new sample is taken every cycle while the output
// register is free or being drained. After every BLOCK = FFT_SIZE - OVERLAP_LEN
// samples the block runs its batch: load, forward fft (N/2*log2(N) butterflies,
// each read, multiplied, added and written back in two halves), weighting,
// inverse fft, output pass. A single butterfly unit with one work-memory write
// port does all the fft work. in_tready stays low during the batch and in the
// start cycle before it.
// Reset: synchronous, active low; no clearing pass is needed, stores read before
// they are written are masked by a first-block flag.
// A stalled receiver holds the result in the output register and in_tready drops.
`default_nettype none

module fft_overlap_add_hilbert #(
  parameter int FFT_SIZE    = 1024,
  parameter int OVERLAP_LEN = 256
) (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_tvalid,
  output logic        in_tready,
  input  wire [15:0]  in_tdata,    // [15:0] sample_in
  output logic        out_tvalid,
  input  wire         out_tready,
  output logic [39:0] out_tdata    // [17:0] out_re, [35:18] out_im, [39:36] zero
);
  import foah_pkg::*;

  localparam int AW = $clog2(FFT_SIZE);
  localparam int SW = $clog2(AW);

  foah_cmd_t     cmd;
  foah_sts_t     sts;
  logic [AW-1:0] idx;
  logic [SW-1:0] stage;

  foah_ctrl #(
    .FFT_SIZE (FFT_SIZE)
  ) u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .sts   (sts),
    .cmd   (cmd),
    .idx   (idx),
    .stage (stage)
  );

  foah_dp #(
    .FFT_SIZE    (FFT_SIZE),
    .OVERLAP_LEN (OVERLAP_LEN)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .idx        (idx),
    .stage      (stage),
    .sts        (sts),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  a_no_accept_in_batch: assert property (@(posedge clk) disable iff (!rst_n)
    !cmd.idle |-> !in_tready) else $error("input taken during block batch");

  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> out_tvalid) else $error("missing result");

  a_batch_starts: assert property (@(posedge clk) disable iff (!rst_n)
    sts.start |=> !cmd.idle) else $error("full block not processed");

endmodule

`default_nettype wire

// File: rtl/foah_ctrl.sv
// foah_ctrl: sequencer for one block: load, forward fft, weighting, inverse fft
// and overlap-add output pass. Depends on foah_pkg.
`default_nettype none

module foah_ctrl #(
  parameter int FFT_SIZE = 1024
) (
  input  wire                           clk,
  input  wire                           rst_n,
  input  foah_pkg::foah_sts_t           sts,
  output foah_pkg::foah_cmd_t           cmd,
  output logic [$clog2(FFT_SIZE)-1:0]   idx,
  output logic [$clog2($clog2(FFT_SIZE))-1:0] stage
);
  import foah_pkg::*;

  localparam int AW   = $clog2(FFT_SIZE);
  localparam int SW   = $clog2(AW);
  localparam int HALF = FFT_SIZE / 2;

  foah_state_t   state_r, state_nxt;
  logic [AW-1:0] idx_r, idx_nxt;
  logic [SW-1:0] stage_r, stage_nxt;
  logic          inv_r, inv_nxt;
  logic          bf_last, stage_last;

  assign bf_last    = (idx_r == AW'(HALF - 1));
  assign stage_last = (stage_r == SW'(AW - 1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      idx_r   <= '0;
      stage_r <= '0;
      inv_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
      stage_r <= stage_nxt;
      inv_r   <= inv_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    stage_nxt = stage_r;
    inv_nxt   = inv_r;
    cmd.op    = OP_NONE;
    cmd.inv   = inv_r;
    cmd.idle  = (state_r == ST_IDLE);
    unique case (state_r)
      ST_IDLE: begin
        if (sts.start) begin
          state_nxt = ST_LOAD_RD;
          idx_nxt   = '0;
          inv_nxt   = 1'b0;
        end
      end
      ST_LOAD_RD: begin
        cmd.op    = OP_LOAD_RD;
        state_nxt = ST_LOAD_WR;
      end
      ST_LOAD_WR: begin
        cmd.op = OP_LOAD_WR;
        if (&idx_r) begin
          idx_nxt   = '0;
          stage_nxt = '0;
          state_nxt = ST_BF_RD;
        end else begin
          idx_nxt   = idx_r + 1'b1;
          state_nxt = ST_LOAD_RD;
        end
      end
      ST_BF_RD: begin
        cmd.op    = OP_BF_RD;
        state_nxt = ST_BF_MUL;
      end
      ST_BF_MUL: begin
        cmd.op    = OP_BF_MUL;
        state_nxt = ST_BF_ADD;
      end
      ST_BF_ADD: begin
        cmd.op    = OP_BF_ADD;
        state_nxt = ST_BF_WA;
      end
      ST_BF_WA: begin
        cmd.op    = OP_BF_WA;
        state_nxt = ST_BF_WB;
      end
      ST_BF_WB: begin
        cmd.op = OP_BF_WB;
        if (bf_last) begin
          idx_nxt = '0;
          if (stage_last) begin
            stage_nxt = '0;
            state_nxt = inv_r ? ST_OUT_RD : ST_WT_RD;
          end else begin
            stage_nxt = stage_r + 1'b1;
            state_nxt = ST_BF_RD;
          end
        end else begin
          idx_nxt   = idx_r + 1'b1;
          state_nxt = ST_BF_RD;
        end
      end
      ST_WT_RD: begin
        cmd.op    = OP_WT_RD;
        state_nxt = ST_WT_WR;
      end
      ST_WT_WR: begin
        cmd.op = OP_WT_WR;
        if (&idx_r) begin
          idx_nxt   = '0;
          inv_nxt   = 1'b1;
          state_nxt = ST_BF_RD;
        end else begin
          idx_nxt   = idx_r + 1'b1;
          state_nxt = ST_WT_RD;
        end
      end
      ST_OUT_RD: begin
        cmd.op    = OP_OUT_RD;
        state_nxt = ST_OUT_WR;
      end
      ST_OUT_WR: begin
        cmd.op = OP_OUT_WR;
        if (&idx_r) begin
          idx_nxt   = '0;
          inv_nxt   = 1'b0;
          state_nxt = ST_IDLE;
        end else begin
          idx_nxt   = idx_r + 1'b1;
          state_nxt = ST_OUT_RD;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign idx      = idx_r;
  assign stage    = stage_r;

endmodule

`default_nettype wire

// File: rtl/foah_dp.sv
// foah_dp: stream buffers, fft work memory, twiddle rom, butterfly and
// overlap-add arithmetic. Driven by foah_ctrl; depends on foah_pkg.
`default_nettype none

module foah_dp #(
  parameter int FFT_SIZE    = 1024,
  parameter int OVERLAP_LEN = 256
) (
  input  wire                                 clk,
  input  wire                                 rst_n,
  input  foah_pkg::foah_cmd_t                 cmd,
  input  wire [$clog2(FFT_SIZE)-1:0]          idx,
  input  wire [$clog2($clog2(FFT_SIZE))-1:0]  stage,
  output foah_pkg::foah_sts_t                 sts,
  input  wire                                 in_tvalid,
  output logic                                in_tready,
  input  wire [15:0]                          in_tdata,
  output logic                                out_tvalid,
  input  wire                                 out_tready,
  output logic [39:0]                         out_tdata
);
  import foah_pkg::*;

  localparam int N     = FFT_SIZE;
  localparam int AW    = $clog2(N);
  localparam int SW    = $clog2(AW);
  localparam int HALF  = N / 2;
  localparam int BLOCK = N - OVERLAP_LEN;
  localparam int BW    = (BLOCK > 1) ? $clog2(BLOCK) : 1;
  localparam int OW    = (OVERLAP_LEN > 1) ? $clog2(OVERLAP_LEN) : 1;

  // stream side
  logic [BW-1:0] wp_r;
  logic          first_r, start_r, out_valid_r, acc, wp_last;
  logic [35:0]   out_data_r;

  // storage
  logic signed [15:0] inbuf [N];
  logic [47:0]        work [2*N];
  logic [35:0]        outbuf [BLOCK];
  logic [35:0]        ovl [OVERLAP_LEN];
  logic [47:0]        rom [HALF];

  logic signed [15:0] in_q;
  logic [47:0]        rd0_q, rd1_q, tw_q;
  logic [35:0]        ov_q;
  logic [AW:0]        rd0_addr, rd1_addr, wr_addr;
  logic               wr_en;
  logic [47:0]        wr_data;

  // butterfly
  logic [AW-1:0]      mask, ia, ib, idx_rev, tw_full;
  logic [SW-1:0]      tw_sh;
  logic [AW-2:0]      tw_addr;
  logic signed [23:0] br, bi, c, s, ar, ai;
  logic [47:0]        a_r, ya_r, yb_r;
  logic signed [47:0] p_brc_r, p_bis_r, p_bic_r, p_brs_r;
  logic signed [48:0] pr, pim;
  logic signed [26:0] tr, ti;

  // weighting and output pass
  logic [47:0]        wt_data;
  logic signed [19:0] qr, qi;
  logic signed [20:0] sr, si;
  logic               use_ov;
  logic [35:0]        out_word, tail_word;

  for (genvar k = 0; k < HALF; k++) begin : g_rom
    assign rom[k] = tw_entry(k, AW);
  end

  function automatic logic signed [23:0] bf_out(input logic signed [23:0] a,
                                                input logic signed [26:0] t,
                                                input logic sub, input logic inv);
    logic signed [28:0] v;
    v = sub ? (29'(a) - 29'(t)) : (29'(a) + 29'(t));
    if (!inv) v = (v + 29'sd1) >>> 1;
    return sat24(30'(v));
  endfunction

  // ---------------- stream handshake
  assign wp_last   = (wp_r == BW'(BLOCK - 1));
  assign in_tready = cmd.idle & ~start_r & (~out_valid_r | out_tready);
  assign acc       = in_tvalid & in_tready;
  assign sts.start = start_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r        <= '0;
      first_r     <= 1'b0;
      start_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      start_r <= acc & wp_last;
      if (acc) begin
        out_valid_r <= 1'b1;
        wp_r        <= wp_last ? '0 : wp_r + 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      if (cmd.op == OP_OUT_WR && (&idx)) first_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      inbuf[AW'(wp_r)] <= $signed(in_tdata);
      out_data_r       <= first_r ? outbuf[wp_r] : '0;
    end
    in_q <= inbuf[idx];
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'b0, out_data_r};

  // ---------------- addressing
  always_comb begin
    for (int b = 0; b < AW; b++) idx_rev[b] = idx[AW-1-b];
  end

  always_comb begin
    mask    = (AW'(1) << stage) - AW'(1);
    ia      = ((idx & ~mask) << 1) | (idx & mask);
    ib      = ia | (AW'(1) << stage);
    tw_sh   = SW'(AW - 1) - stage;
    tw_full = (idx & mask) << tw_sh;
    tw_addr = tw_full[AW-2:0];
  end

  always_comb begin
    rd0_addr = {1'b0, idx};
    rd1_addr = {1'b0, idx};
    case (cmd.op)
      OP_BF_RD: begin
        rd0_addr = {cmd.inv, ia};
        rd1_addr = {cmd.inv, ib};
      end
      OP_OUT_RD: begin
        rd0_addr = {1'b1, idx};
        rd1_addr = {1'b1, idx + AW'(BLOCK)};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    rd0_q <= work[rd0_addr];
    rd1_q <= work[rd1_addr];
    tw_q  <= rom[tw_addr];
    ov_q  <= ovl[idx[OW-1:0]];
    if (wr_en) work[wr_addr] <= wr_data;
  end

  // ---------------- butterfly
  assign br = rd1_q[47:24];
  assign bi = rd1_q[23:0];
  assign c  = tw_q[47:24];
  assign s  = tw_q[23:0];
  assign ar = a_r[47:24];
  assign ai = a_r[23:0];

  always_ff @(posedge clk) begin
    if (cmd.op == OP_BF_MUL) begin
      a_r     <= rd0_q;
      p_brc_r <= br * c;
      p_bis_r <= bi * s;
      p_bic_r <= bi * c;
      p_brs_r <= br * s;
    end
    if (cmd.op == OP_BF_ADD) begin
      ya_r <= {bf_out(ar, tr, 1'b0, cmd.inv), bf_out(ai, ti, 1'b0, cmd.inv)};
      yb_r <= {bf_out(ar, tr, 1'b1, cmd.inv), bf_out(ai, ti, 1'b1, cmd.inv)};
    end
  end

  always_comb begin
    logic signed [48:0] rr, ri;
    if (cmd.inv) begin
      pr  = 49'(p_brc_r) - 49'(p_bis_r);
      pim = 49'(p_bic_r) + 49'(p_brs_r);
    end else begin
      pr  = 49'(p_brc_r) + 49'(p_bis_r);
      pim = 49'(p_bic_r) - 49'(p_brs_r);
    end
    rr = pr + 49'sd2097152;
    ri = pim + 49'sd2097152;
    tr = rr[48:22];
    ti = ri[48:22];
  end

  // ---------------- spectrum weighting: dc and nyquist kept, other lower bins doubled, upper half cleared
  always_comb begin
    if (idx == '0 || idx == AW'(HALF)) wt_data = rd0_q;
    else if (idx < AW'(HALF))
      wt_data = {sat24(30'($signed(rd0_q[47:24])) <<< 1),
                 sat24(30'($signed(rd0_q[23:0])) <<< 1)};
    else wt_data = '0;
  end

  // ---------------- overlap-add
  always_comb begin
    qr        = q15(rd0_q[47:24]);
    qi        = q15(rd0_q[23:0]);
    use_ov    = first_r && (idx < AW'(OVERLAP_LEN));
    sr        = 21'(qr) + (use_ov ? 21'($signed(ov_q[17:0])) : 21'sd0);
    si        = 21'(qi) + (use_ov ? 21'($signed(ov_q[35:18])) : 21'sd0);
    out_word  = {sat18(22'(si)), sat18(22'(sr))};
    tail_word = {sat18(22'(q15(rd1_q[23:0]))), sat18(22'(q15(rd1_q[47:24])))};
  end

  always_ff @(posedge clk) begin
    if (cmd.op == OP_OUT_WR) begin
      if (idx < AW'(BLOCK)) outbuf[idx[BW-1:0]] <= out_word;
      if (idx < AW'(OVERLAP_LEN)) ovl[idx[OW-1:0]] <= tail_word;
    end
  end

  // ---------------- work memory write port
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = {1'b0, idx_rev};
    wr_data = ya_r;
    case (cmd.op)
      OP_LOAD_WR: begin
        wr_en   = 1'b1;
        wr_addr = {1'b0, idx_rev};
        wr_data = (idx < AW'(BLOCK)) ? {{3{in_q[15]}}, in_q, 5'b0, 24'b0} : '0;
      end
      OP_BF_WA: begin
        wr_en   = 1'b1;
        wr_addr = {cmd.inv, ia};
        wr_data = ya_r;
      end
      OP_BF_WB: begin
        wr_en   = 1'b1;
        wr_addr = {cmd.inv, ib};
        wr_data = yb_r;
      end
      OP_WT_WR: begin
        wr_en   = 1'b1;
        wr_addr = {1'b1, idx_rev};
        wr_data = wt_data;
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

// File: bench/hilbert_scoreboard.sv
// hilbert_scoreboard: watches the sample and result streams of fft_overlap_add_hilbert,
// predicts each analytic sample with a fixed-point overlap-add model and compares.
// Depends only on the channel signals; no package functions are used.
`default_nettype none

module hilbert_scoreboard #(
  parameter int FFT_SIZE    = 1024,
  parameter int OVERLAP_LEN = 256
) (
  input  wire        clk,
  input  wire        rst_n,
  input  wire        in_tvalid,
  input  wire        in_tready,
  input  wire [15:0] in_tdata,
  input  wire        out_tvalid,
  input  wire        out_tready,
  input  wire [39:0] out_tdata,
  output int         fail_count,
  output int         pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int BLK = FFT_SIZE - OVERLAP_LEN;
  localparam longint unsigned PI_FIX = 64'd3373259426;

  typedef struct packed {
    logic signed [17:0] re;
    logic signed [17:0] im;
  } analytic_t;

  longint cos_rom [FFT_SIZE/2];
  longint sin_rom [FFT_SIZE/2];
  logic signed [15:0] samples [FFT_SIZE];
  longint work_re [FFT_SIZE];
  longint work_im [FFT_SIZE];
  analytic_t out_buf [FFT_SIZE];
  analytic_t tail_buf [OVERLAP_LEN];
  int fill_pos;
  analytic_t expected_q [$];

  function automatic longint clip(input longint v, input int bits);
    longint hi;
    hi = (64'sd1 <<< (bits - 1)) - 1;
    if (v > hi) return hi;
    if (v < -hi - 1) return -hi - 1;
    return v;
  endfunction

  function automatic longint to_q15(input longint v);
    return (v + 16) >>> 5;
  endfunction

  task automatic build_twiddles();
    longint unsigned kk, x, x2, tc, ts;
    longint sc, ss;
    bit flip;
    for (int k = 0; k < FFT_SIZE / 2; k++) begin
      flip = 4 * k > FFT_SIZE;
      kk = flip ? longint'(FFT_SIZE / 2 - k) : longint'(k);
      x = (PI_FIX * 2 * kk) / FFT_SIZE;
      x2 = (x * x) >> 30;
      tc = 64'd1 << 30;
      ts = x;
      sc = longint'(tc);
      ss = longint'(ts);
      for (int n = 1; n <= 12; n++) begin
        tc = ((tc * x2) >> 30) / longint'((2 * n - 1) * (2 * n));
        ts = ((ts * x2) >> 30) / longint'((2 * n) * (2 * n + 1));
        if (n & 1) begin
          sc -= longint'(tc);
          ss -= longint'(ts);
        end else begin
          sc += longint'(tc);
          ss += longint'(ts);
        end
      end
      sc = (sc + 128) >>> 8;
      ss = (ss + 128) >>> 8;
      cos_rom[k] = flip ? -sc : sc;
      sin_rom[k] = ss;
    end
  endtask

  task automatic radix2(input bit inverse);
    int bits, r, half, stride;
    longint c, s, ar, ai, br, bi, pr, pi, tr, ti, t;
    bits = $clog2(FFT_SIZE);
    for (int i = 0; i < FFT_SIZE; i++) begin
      r = 0;
      for (int b = 0; b < bits; b++) r |= ((i >> b) & 1) << (bits - 1 - b);
      if (r > i) begin
        t = work_re[i]; work_re[i] = work_re[r]; work_re[r] = t;
        t = work_im[i]; work_im[i] = work_im[r]; work_im[r] = t;
      end
    end
    for (int len = 2; len <= FFT_SIZE; len <<= 1) begin
      half = len / 2;
      stride = FFT_SIZE / len;
      for (int base = 0; base < FFT_SIZE; base += len) begin
        for (int j = 0; j < half; j++) begin
          c = cos_rom[j * stride];
          s = sin_rom[j * stride];
          ar = work_re[base + j];
          ai = work_im[base + j];
          br = work_re[base + j + half];
          bi = work_im[base + j + half];
          if (inverse) begin
            pr = br * c - bi * s;
            pi = bi * c + br * s;
          end else begin
            pr = br * c + bi * s;
            pi = bi * c - br * s;
          end
          tr = (pr + (64'sd1 <<< 21)) >>> 22;
          ti = (pi + (64'sd1 <<< 21)) >>> 22;
          if (inverse) begin
            work_re[base + j] = clip(ar + tr, 24);
            work_im[base + j] = clip(ai + ti, 24);
            work_re[base + j + half] = clip(ar - tr, 24);
            work_im[base + j + half] = clip(ai - ti, 24);
          end else begin
            work_re[base + j] = clip((ar + tr + 1) >>> 1, 24);
            work_im[base + j] = clip((ai + ti + 1) >>> 1, 24);
            work_re[base + j + half] = clip((ar - tr + 1) >>> 1, 24);
            work_im[base + j + half] = clip((ai - ti + 1) >>> 1, 24);
          end
        end
      end
    end
  endtask

  task automatic process_block();
    longint r, m;
    analytic_t tail;
    for (int i = 0; i < FFT_SIZE; i++) begin
      work_re[i] = i < BLK ? longint'(samples[i]) * 32 : 0;
      work_im[i] = 0;
    end
    radix2(1'b0);
    // keep dc and nyquist, double positive bins, drop negative ones
    for (int i = 1; i < FFT_SIZE; i++) begin
      if (i < FFT_SIZE / 2) begin
        work_re[i] = clip(work_re[i] * 2, 24);
        work_im[i] = clip(work_im[i] * 2, 24);
      end else if (i > FFT_SIZE / 2) begin
        work_re[i] = 0;
        work_im[i] = 0;
      end
    end
    radix2(1'b1);
    for (int i = 0; i < FFT_SIZE; i++) begin
      r = to_q15(work_re[i]);
      m = to_q15(work_im[i]);
      if (i < OVERLAP_LEN) begin
        // tail saved before this block's overlap addition
        tail.re = clip(to_q15(work_re[BLK + i]), 18);
        tail.im = clip(to_q15(work_im[BLK + i]), 18);
        r += tail_buf[i].re;
        m += tail_buf[i].im;
        tail_buf[i] = tail;
      end
      out_buf[i].re = clip(r, 18);
      out_buf[i].im = clip(m, 18);
    end
  endtask

  initial begin
    build_twiddles();
  end

  analytic_t got, want;

  always @(posedge clk) begin
    if (!rst_n) begin
      foreach (samples[i]) samples[i] = '0;
      foreach (out_buf[i]) out_buf[i] = '0;
      foreach (tail_buf[i]) tail_buf[i] = '0;
      fill_pos = 0;
      expected_q.delete();
      fail_count <= 0;
    end else begin
      if (in_tvalid && in_tready) begin
        expected_q.push_back(out_buf[fill_pos]);
        samples[fill_pos] = in_tdata;
        fill_pos++;
        if (fill_pos >= BLK) begin
          fill_pos = 0;
          process_block();
        end
      end
      if (out_tvalid && out_tready) begin
        got.re = out_tdata[17:0];
        got.im = out_tdata[35:18];
        if (expected_q.size() == 0) begin
          $display("%0t: unexpected result re=%0d im=%0d", $time, got.re, got.im);
          fail_count <= fail_count + 1;
        end else begin
          want = expected_q.pop_front();
          if (got.re !== want.re || got.im !== want.im || out_tdata[39:36] !== 4'd0) begin
            $display("%0t: mismatch expected re=%0d im=%0d actual re=%0d im=%0d pad=%h",
                     $time, want.re, want.im, got.re, got.im, out_tdata[39:36]);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
    pending = expected_q.size();
  end
endmodule

`default_nettype wire

// File: bench/fft_overlap_add_hilbert_tb.sv
// fft_overlap_add_hilbert_tb: drives real samples into the hilbert block with random
// gaps and output stalls; hilbert_scoreboard predicts and checks every result.
`default_nettype none

module fft_overlap_add_hilbert_tb;
  timeunit 1ns;
  timeprecision 1ps;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic [15:0] in_tdata = '0;
  logic out_tready = 1'b0;
  wire in_tready, out_tvalid;
  wire [39:0] out_tdata;
  int fail_count, pending;
  bit sending_done = 1'b0;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  fft_overlap_add_hilbert u_top (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  hilbert_scoreboard u_check (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .fail_count(fail_count), .pending(pending)
  );

  // send one request; stays valid until accepted, dropped only before a gap
  task automatic send_sample(input logic [15:0] value, input int gap);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= value;
    do @(posedge clk); while (!in_tready);
  endtask

  function automatic logic [15:0] pick_sample(input int idx);
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 16'h7fff;
    if (r == 1) return 16'h8000;
    if (r < 5) return 16'($signed(int'(12000.0 * $sin(idx * 0.0491))));
    return 16'($urandom);
  endfunction

  // receiver stall pattern; quiet stretches with no stalls
  initial begin
    int wait_cycles;
    @(posedge rst_n);
    forever begin
      wait_cycles = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 10);
      if (wait_cycles > 0) begin
        out_tready <= 1'b0;
        repeat (wait_cycles) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
    end
  end

  initial begin
    int dense;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    // extremes and the first block being all zero outputs
    send_sample(16'h7fff, 0);
    send_sample(16'h8000, 0);
    send_sample(16'h0000, 1);
    send_sample(16'h0001, 0);
    send_sample(16'hffff, 0);
    send_sample(16'h5555, 2);
    send_sample(16'haaaa, 0);
    for (int i = 0; i < 1093; i++) begin
      if (i == 700) begin
        in_tvalid <= 1'b0;
        @(posedge clk);
        wait (pending == 0);
        @(posedge clk);
      end
      dense = ((i / 150) % 2 == 0);
      send_sample(pick_sample(i), dense ? 0 : $urandom_range(0, 10));
    end
    in_tvalid <= 1'b0;
    sending_done = 1'b1;
  end

  initial begin
    wait (sending_done);
    wait (pending == 0);
    repeat (200) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("FAILURE");
    $finish;
  end
endmodule

`default_nettype wire
